// ===== sv/bha_pkg.sv =====
// ----------------------------------------------------------------------------
// bha_pkg: shared definitions of the buddy heap allocator
// Heap geometry, free-list entry layout, sequencer states and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bha_pkg;

  localparam int unsigned HEAP_BYTES      = 65536;
  localparam int unsigned MIN_BLOCK_BYTES = 512;
  localparam int unsigned ALIGN_BYTES     = 8;
  localparam int unsigned HEADER_BYTES    = 24;

  localparam int unsigned NUM_SLOTS = HEAP_BYTES / MIN_BLOCK_BYTES;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);
  localparam int unsigned MINB_W    = $clog2(MIN_BLOCK_BYTES);
  localparam int unsigned ORD_W     = 3;
  localparam int unsigned CNT_W     = SLOT_W + 1;
  localparam int unsigned BYTES_W   = 17;
  localparam logic [ORD_W-1:0] TOP_ORDER = ORD_W'(SLOT_W);

  // opcodes of an input word
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ORD_W-1:0]  ord;
  } fl_entry_t;

  localparam int unsigned ENTRY_W = $bits(fl_entry_t);

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_SPLIT,
    S_RM_RD,
    S_RM_WR,
    S_INS_START,
    S_INS_RD,
    S_INS_CHK,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_F_RD,
    S_F_ORD,
    S_MERGE,
    S_FIND_RD,
    S_FIND_CHK,
    S_FIN_FREE
  } state_e;

  // size in bytes of a block of the given order
  function automatic logic [BYTES_W-1:0] block_bytes(input logic [ORD_W-1:0] o);
    block_bytes = BYTES_W'(MIN_BLOCK_BYTES) << o;
  endfunction

endpackage

`default_nettype wire

// ===== sv/bha_ram.sv =====
// ----------------------------------------------------------------------------
// bha_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/buddy_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_heap_allocator: buddy allocator over a 64 KiB heap
// Usage: an input word (opcode, request_bytes, block_address) is taken on
// in_valid_i & in_ready_o. Opcode 0 allocates, opcode 1 frees an address
// returned earlier. Each input gives one output word (ok, address,
// free_bytes) on out_valid_o & out_ready_i.
// The free list, sorted by order, lives in a 128-entry RAM walked by one
// sequencer; its RAM reads return registered data.
// A rejected word has its result in the cycle after acceptance. A granted
// allocate scans the list and removes the entry it takes; an insert or
// remove shifts the entries behind it, and an allocate may split up to 7
// times, a free merge up to 7 times.
// The block takes one word at a time; in_ready_o is low while it works.
// A result waits in the output register while the receiver stalls; a new
// word is taken in the cycle the pending result is accepted.
// After reset the sequencer writes the whole-heap entry into the list RAM,
// then in_ready_o rises. The free byte count resets to 65536.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_heap_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [0:0]  opcode_i,
  input  wire logic [19:0] request_bytes_i,
  input  wire logic [15:0] block_address_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [0:0]       ok_o,
  output logic [15:0]      address_o,
  output logic [16:0]      free_bytes_o
);

  import bha_pkg::*;

  state_e state_q, state_d, ret_q, ret_d;
  logic               init_q, init_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, idx_q, idx_d, ptr_q, ptr_d;
  logic [SLOT_W-1:0]  slot_q, slot_d, kslot_q, kslot_d;
  logic [ORD_W-1:0]   ord_q, ord_d, kord_q, kord_d;
  logic [BYTES_W-1:0] need_q, need_d, size_q, size_d, bytes_q, bytes_d;
  logic               out_valid_q, out_valid_d;
  logic               ok_q, ok_d;
  logic [15:0]        addr_q, addr_d;

  // list RAM ports
  logic              fl_we;
  logic [SLOT_W-1:0] fl_waddr, fl_raddr;
  fl_entry_t         fl_wdata, fl_rdata;
  // allocated-order RAM ports
  logic              al_we;
  logic [ORD_W-1:0]  al_rdata;

  // input decode
  logic [20:0] need_raw, need_al;
  logic [15:0] offs;
  logic        free_ok;
  logic [BYTES_W:0] bsum;

  assign need_raw = 21'(request_bytes_i) + 21'(HEADER_BYTES);
  assign need_al  = (need_raw + 21'(ALIGN_BYTES - 1)) & ~21'(ALIGN_BYTES - 1);
  assign offs     = block_address_i - 16'(HEADER_BYTES);
  assign free_ok  = (block_address_i >= 16'(HEADER_BYTES)) && (offs[MINB_W-1:0] == '0);
  assign bsum     = {1'b0, bytes_q} + {1'b0, size_q};

  bha_ram #(.Width(ENTRY_W), .Depth(NUM_SLOTS)) u_fl_ram (
    .clk_i  (clk_i),
    .we_i   (fl_we),
    .waddr_i(fl_waddr),
    .wdata_i(fl_wdata),
    .raddr_i(fl_raddr),
    .rdata_o(fl_rdata)
  );

  bha_ram #(.Width(ORD_W), .Depth(NUM_SLOTS)) u_al_ram (
    .clk_i  (clk_i),
    .we_i   (al_we),
    .waddr_i(slot_q),
    .wdata_i(ord_q),
    .raddr_i(slot_q),
    .rdata_o(al_rdata)
  );

  assign in_ready_o   = (state_q == S_IDLE) && !init_q && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign address_o    = addr_q;
  assign free_bytes_o = bytes_q;

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      init_q      <= 1'b1;
      cnt_q       <= CNT_W'(1);
      bytes_q     <= BYTES_W'(HEAP_BYTES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      init_q      <= init_d;
      cnt_q       <= cnt_d;
      bytes_q     <= bytes_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    ptr_q   <= ptr_d;
    slot_q  <= slot_d;
    ord_q   <= ord_d;
    kslot_q <= kslot_d;
    kord_q  <= kord_d;
    need_q  <= need_d;
    size_q  <= size_d;
    ok_q    <= ok_d;
    addr_q  <= addr_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    init_d      = init_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    slot_d      = slot_q;
    ord_d       = ord_q;
    kslot_d     = kslot_q;
    kord_d      = kord_q;
    need_d      = need_q;
    size_d      = size_q;
    bytes_d     = bytes_q;
    ok_d        = ok_q;
    addr_d      = addr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    fl_we       = 1'b0;
    fl_waddr    = '0;
    fl_wdata    = '{slot: '0, ord: TOP_ORDER};
    fl_raddr    = idx_q[SLOT_W-1:0];
    al_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (init_q) begin
          // whole heap as the only free block
          fl_we  = 1'b1;
          init_d = 1'b0;
        end else if (in_valid_i && in_ready_o) begin
          idx_d = '0;
          if (opcode_i == OP_ALLOC) begin
            if (request_bytes_i != '0 && need_al <= 21'(HEAP_BYTES)) begin
              need_d  = need_al[BYTES_W-1:0];
              state_d = S_A_RD;
            end else begin
              ok_d        = 1'b0;
              addr_d      = '0;
              out_valid_d = 1'b1;
            end
          end else if (free_ok) begin
            slot_d  = offs[MINB_W +: SLOT_W];
            state_d = S_F_RD;
          end else begin
            ok_d        = 1'b0;
            addr_d      = '0;
            out_valid_d = 1'b1;
          end
        end
      end

      // first-fit scan
      S_A_RD: begin
        if (idx_q < cnt_q) begin
          state_d = S_A_CHK;
        end else begin
          ok_d        = 1'b0;
          addr_d      = '0;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_A_CHK: begin
        if (block_bytes(fl_rdata.ord) >= need_q) begin
          slot_d  = fl_rdata.slot;
          ord_d   = fl_rdata.ord;
          ret_d   = S_SPLIT;
          state_d = S_RM_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_A_RD;
        end
      end

      // halve while the half still fits
      S_SPLIT: begin
        if (ord_q != '0 && block_bytes(ord_q - 1'b1) >= need_q) begin
          ord_d   = ord_q - 1'b1;
          kord_d  = ord_q - 1'b1;
          kslot_d = slot_q | (SLOT_W'(1) << (ord_q - 1'b1));
          ret_d   = S_SPLIT;
          state_d = S_INS_START;
        end else begin
          al_we       = 1'b1;
          size_d      = block_bytes(ord_q);
          bytes_d     = (bytes_q > block_bytes(ord_q)) ? bytes_q - block_bytes(ord_q) : '0;
          ok_d        = 1'b1;
          addr_d      = 16'({slot_q, MINB_W'(0)}) + 16'(HEADER_BYTES);
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      // remove entry idx: shift the tail down by one
      S_RM_RD: begin
        if (idx_q + 1'b1 < cnt_q) begin
          fl_raddr = SLOT_W'(idx_q + 1'b1);
          state_d  = S_RM_WR;
        end else begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ret_q;
        end
      end
      S_RM_WR: begin
        fl_we    = 1'b1;
        fl_waddr = idx_q[SLOT_W-1:0];
        fl_wdata = fl_rdata;
        idx_d    = idx_q + 1'b1;
        state_d  = S_RM_RD;
      end

      // sorted insert of the key entry; dropped when the list is full
      S_INS_START: begin
        idx_d   = '0;
        state_d = (cnt_q >= CNT_W'(NUM_SLOTS)) ? ret_q : S_INS_RD;
      end
      S_INS_RD: begin
        if (idx_q < cnt_q) begin
          state_d = S_INS_CHK;
        end else begin
          ptr_d   = cnt_q;
          state_d = S_SH_RD;
        end
      end
      S_INS_CHK: begin
        if (fl_rdata.ord < kord_q) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_INS_RD;
        end else begin
          ptr_d   = cnt_q;
          state_d = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (ptr_q > idx_q) begin
          fl_raddr = SLOT_W'(ptr_q - 1'b1);
          state_d  = S_SH_WR;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_SH_WR: begin
        fl_we    = 1'b1;
        fl_waddr = ptr_q[SLOT_W-1:0];
        fl_wdata = fl_rdata;
        ptr_d    = ptr_q - 1'b1;
        state_d  = S_SH_RD;
      end
      S_INS_WR: begin
        fl_we    = 1'b1;
        fl_waddr = idx_q[SLOT_W-1:0];
        fl_wdata = '{slot: kslot_q, ord: kord_q};
        cnt_d    = cnt_q + 1'b1;
        state_d  = ret_q;
      end

      // free: fetch the stored order
      S_F_RD: begin
        state_d = S_F_ORD;
      end
      S_F_ORD: begin
        ord_d   = (al_rdata > TOP_ORDER) ? TOP_ORDER : al_rdata;
        size_d  = block_bytes((al_rdata > TOP_ORDER) ? TOP_ORDER : al_rdata);
        state_d = S_MERGE;
      end

      // merge with free buddies
      S_MERGE: begin
        if (ord_q >= TOP_ORDER) begin
          fl_we    = 1'b1;
          cnt_d    = CNT_W'(1);
          state_d  = S_FIN_FREE;
        end else begin
          kslot_d = slot_q ^ (SLOT_W'(1) << ord_q);
          kord_d  = ord_q;
          idx_d   = '0;
          state_d = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        if (idx_q < cnt_q) begin
          state_d = S_FIND_CHK;
        end else begin
          kslot_d = slot_q;
          kord_d  = ord_q;
          ret_d   = S_FIN_FREE;
          state_d = S_INS_START;
        end
      end
      S_FIND_CHK: begin
        if (fl_rdata.slot == kslot_q && fl_rdata.ord == kord_q) begin
          slot_d  = slot_q & ~(SLOT_W'(1) << ord_q);
          ord_d   = ord_q + 1'b1;
          ret_d   = S_MERGE;
          state_d = S_RM_RD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_FIN_FREE: begin
        bytes_d     = (bsum > (BYTES_W+1)'(HEAP_BYTES)) ? BYTES_W'(HEAP_BYTES)
                                                        : bsum[BYTES_W-1:0];
        ok_d        = 1'b1;
        addr_d      = '0;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(NUM_SLOTS))
    else $error("free list count out of range");
  a_bytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= BYTES_W'(HEAP_BYTES))
    else $error("free byte count above heap size");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && $past(state_q) == S_IDLE |-> !$past(out_valid_q && !out_ready_i))
    else $error("item started while a result was still pending");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE) && !init_q)
    else $error("ready while busy");
`endif

endmodule

`default_nettype wire
